@@ src/pfwc_pkg.sv @@
// ----------------------------------------------------------------------------
// PLL frequency word calculator package
// Request and response types, fixed constants and the power code map.
// ----------------------------------------------------------------------------
package pfwc_pkg;

  localparam int FREQ_W = 33;
  localparam int WORD_W = 32;
  localparam int INT_W  = 16;
  localparam int FRAC_W = 12;

  localparam int DEF_PFD_HZ  = 100000;
  localparam int DEF_STEP_HZ = 100;

  localparam logic [FREQ_W-1:0] FREQ_MIN = 33'd100000000;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 33'd4400000000;

  // Lowest frequency that still reaches the VCO range for each divider code.
  localparam logic [FREQ_W-1:0] THR_DIV1  = 33'd2200000000;
  localparam logic [FREQ_W-1:0] THR_DIV2  = 33'd1100000000;
  localparam logic [FREQ_W-1:0] THR_DIV4  = 33'd550000000;
  localparam logic [FREQ_W-1:0] THR_DIV8  = 33'd275000000;
  localparam logic [FREQ_W-1:0] THR_DIV16 = 33'd137500000;

  localparam logic [2:0] CODE_DIV1  = 3'd0;
  localparam logic [2:0] CODE_DIV2  = 3'd1;
  localparam logic [2:0] CODE_DIV4  = 3'd2;
  localparam logic [2:0] CODE_DIV8  = 3'd3;
  localparam logic [2:0] CODE_DIV16 = 3'd4;
  localparam logic [2:0] CODE_DIV32 = 3'd5;

  localparam logic [2:0] ADDR_R0 = 3'd0;
  localparam logic [2:0] ADDR_R4 = 3'd4;

  localparam logic [7:0] BAND_SEL_DIV = 8'd1;

  localparam logic signed [3:0] PWR_M4 = -4'sd4;
  localparam logic signed [3:0] PWR_M1 = -4'sd1;
  localparam logic signed [3:0] PWR_P2 = 4'sd2;

  localparam logic [1:0] PCODE_M4 = 2'd0;
  localparam logic [1:0] PCODE_M1 = 2'd1;
  localparam logic [1:0] PCODE_P2 = 2'd2;
  localparam logic [1:0] PCODE_P5 = 2'd3;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_hz;
    logic signed [3:0] power_dbm;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] reg_word;
    logic              last_word;
  } rsp_t;

  function automatic logic [1:0] power_code(input logic signed [3:0] p);
    logic [1:0] c;
    case (p)
      PWR_M4:  c = PCODE_M4;
      PWR_M1:  c = PCODE_M1;
      PWR_P2:  c = PCODE_P2;
      default: c = PCODE_P5;
    endcase
    return c;
  endfunction

endpackage

@@ src/pll_frequency_word_calc.sv @@
// ----------------------------------------------------------------------------
// PLL frequency word calculator
// Turns a frequency and power request into synthesizer register words.
// ----------------------------------------------------------------------------
// A request is taken and clamped, then divided: one quotient bit per cycle for
// the 33-bit integer division by PFD_HZ, then the division of the remainder by
// STEP_HZ, and then the second word is loaded once the output is free. Both
// divisions run on one shared bit-serial restoring divider. The divider/power
// word is offered right after the request is taken; a zero frequency gives a
// single all-zero word and no division.
module pll_frequency_word_calc
  import pfwc_pkg::*;
#(
  parameter int PFD_HZ  = DEF_PFD_HZ,
  parameter int STEP_HZ = DEF_STEP_HZ
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int MAX_DIV = (PFD_HZ > STEP_HZ) ? PFD_HZ : STEP_HZ;
  localparam int DVW     = $clog2(MAX_DIV + 1);
  localparam int CNT_W   = $clog2(FREQ_W);

  localparam logic [DVW-1:0] PFD_DIV  = DVW'(PFD_HZ);
  localparam logic [DVW-1:0] STEP_DIV = DVW'(STEP_HZ);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV1 = 4'b0010,
    S_DIV2 = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t            state;
  logic [FREQ_W-1:0] dvd;
  logic [DVW-1:0]    rem;
  logic [CNT_W-1:0]  cnt;
  logic [INT_W-1:0]  int_q;
  logic [FRAC_W-1:0] frac_q;

  logic [FREQ_W-1:0] freq_clamp;
  logic [2:0]        div_code;
  logic [WORD_W-1:0] word4;
  logic [DVW-1:0]    divisor;
  logic [DVW:0]      trial;
  logic [DVW-1:0]    rem_next;
  logic              take;
  logic              qbit;
  logic              step_last;
  logic              rsp_free;

  always_comb begin
    freq_clamp = req.freq_hz;
    if (req.freq_hz < FREQ_MIN) begin
      freq_clamp = FREQ_MIN;
    end else if (req.freq_hz > FREQ_MAX) begin
      freq_clamp = FREQ_MAX;
    end
    if (freq_clamp >= THR_DIV1) begin
      div_code = CODE_DIV1;
    end else if (freq_clamp >= THR_DIV2) begin
      div_code = CODE_DIV2;
    end else if (freq_clamp >= THR_DIV4) begin
      div_code = CODE_DIV4;
    end else if (freq_clamp >= THR_DIV8) begin
      div_code = CODE_DIV8;
    end else if (freq_clamp >= THR_DIV16) begin
      div_code = CODE_DIV16;
    end else begin
      div_code = CODE_DIV32;
    end
    word4 = {9'd0, div_code, BAND_SEL_DIV, 6'd0, 1'b1, power_code(req.power_dbm),
             ADDR_R4};
  end

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && rsp_free;
  assign take      = req_valid && req_ready;

  assign divisor   = (state == S_DIV1) ? PFD_DIV : STEP_DIV;
  assign trial     = {rem, dvd[FREQ_W-1]};
  assign qbit      = (trial >= {1'b0, divisor});
  assign rem_next  = qbit ? DVW'(trial - {1'b0, divisor}) : trial[DVW-1:0];
  assign step_last = (cnt == CNT_W'(FREQ_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (take || ((state == S_WAIT) && rsp_free)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            cnt <= '0;
            rem <= '0;
            dvd <= freq_clamp;
            if (req.freq_hz == '0) begin
              rsp.reg_word  <= '0;
              rsp.last_word <= 1'b1;
            end else begin
              rsp.reg_word  <= word4;
              rsp.last_word <= 1'b0;
              state         <= S_DIV1;
            end
          end
        end
        S_DIV1, S_DIV2: begin
          if (step_last) begin
            cnt <= '0;
            if (state == S_DIV1) begin
              int_q <= (|dvd[FREQ_W-2:INT_W-1]) ? '1 : {dvd[INT_W-2:0], qbit};
              rem   <= '0;
              dvd   <= FREQ_W'(rem_next);
              state <= S_DIV2;
            end else begin
              frac_q <= (|dvd[FREQ_W-2:FRAC_W-1]) ? '1 : {dvd[FRAC_W-2:0], qbit};
              state  <= S_WAIT;
            end
          end else begin
            rem <= rem_next;
            dvd <= {dvd[FREQ_W-2:0], qbit};
            cnt <= cnt + 1'b1;
          end
        end
        S_WAIT: begin
          if (rsp_free) begin
            rsp.reg_word  <= {1'b0, int_q, frac_q, ADDR_R0};
            rsp.last_word <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
